// ----- design/vle_pkg.sv -----
// Package for the Vigenere letter encryptor: widths, letter constants,
// register addresses and the small letter and modulo helpers.
// No dependencies.
package vle_pkg;

   // Payload and key widths
   localparam int BYTE_W      = 8;
   localparam int SHIFT_W     = 5;
   localparam int POS_W       = 4;
   localparam int LEN_W       = 4;
   localparam int KEY_MAX_DEF = 12;
   localparam int DATA_W      = 64;
   localparam int ADDR_W      = 4;

   // Alphabet
   localparam logic [BYTE_W-1:0]  UPPER_A  = 8'h41;
   localparam logic [BYTE_W-1:0]  UPPER_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0]  LOWER_A  = 8'h61;
   localparam logic [BYTE_W-1:0]  LOWER_Z  = 8'h7A;
   localparam logic [SHIFT_W:0]   ALPHA_N  = 6'd26;

   // Register select (byte address bit 3, registers on 8-byte spacing)
   localparam logic REG_KEY_SHIFTS = 1'b0;
   localparam logic REG_KEY_LENGTH = 1'b1;

   // Shift a letter offset forward by a key shift, modulo the alphabet size
   function automatic logic [SHIFT_W-1:0] add_mod26(input logic [SHIFT_W-1:0] ofs,
                                                    input logic [SHIFT_W-1:0] shift);
      logic [SHIFT_W:0] sh;
      logic [SHIFT_W:0] sum;
      begin
         sh = {1'b0, shift};
         if (sh >= ALPHA_N) begin
            sh = sh - ALPHA_N;
         end
         sum = {1'b0, ofs} + sh;
         if (sum >= ALPHA_N) begin
            sum = sum - ALPHA_N;
         end
         add_mod26 = sum[SHIFT_W-1:0];
      end
   endfunction

endpackage

// ----- design/vigenere_letter_encryptor_top.sv -----
// Top level of the Vigenere letter encryptor: input register, encrypt
// logic, result register and the APB-style key registers. Depends on vle_pkg.
// Flow: an accepted transaction is held in the input register, then encrypted into
// the result register that drives rsp_valid; a full result slot holds it back.
// Throughput: one transaction per cycle unless the result channel stalls, set by the single encrypt pass.
// Reset: synchronous, active high; clears valids, key position and shifts, length one.
module vigenere_letter_encryptor_top #(
   parameter int KEY_MAX = vle_pkg::KEY_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vle_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                          req_restart,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vle_pkg::BYTE_W-1:0]    rsp_out_byte,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vle_pkg::ADDR_W-1:0]    paddr,
   input  logic [vle_pkg::DATA_W-1:0]    pwdata,
   output logic [vle_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   localparam int KEY_W = vle_pkg::SHIFT_W * KEY_MAX;

   // Key registers
   logic [KEY_W-1:0]              key_shifts_ff, key_shifts_in;
   logic [vle_pkg::LEN_W-1:0]     key_length_ff, key_length_in;
   logic [vle_pkg::POS_W-1:0]     key_pos_ff,    key_pos_in;

   // Input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [vle_pkg::BYTE_W-1:0]    s1_byte_ff,  s1_byte_in;
   logic                          s1_restart_ff, s1_restart_in;

   // Result register
   logic                          s2_valid_ff, s2_valid_in;
   logic [vle_pkg::BYTE_W-1:0]    s2_byte_ff,  s2_byte_in;

   logic                          s1_advance;
   logic                          cfg_write;
   logic                          is_upper, is_lower;
   logic [vle_pkg::LEN_W-1:0]     eff_len;
   logic [vle_pkg::POS_W-1:0]     cur_pos, next_pos;
   logic [vle_pkg::SHIFT_W-1:0]   cur_shift, letter_ofs, enc_ofs;
   logic [vle_pkg::BYTE_W-1:0]    letter_base;

   // Handshake: move stage 1 forward when the result slot is free or drains
   assign s1_advance = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign rsp_valid  = s2_valid_ff;
   assign rsp_out_byte = s2_byte_ff;

   // Configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      key_shifts_in = key_shifts_ff;
      key_length_in = key_length_ff;
      if (cfg_write) begin
         unique case (paddr[3])
            vle_pkg::REG_KEY_SHIFTS: key_shifts_in = pwdata[KEY_W-1:0];
            vle_pkg::REG_KEY_LENGTH: key_length_in = pwdata[vle_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         vle_pkg::REG_KEY_SHIFTS:
            prdata = vle_pkg::DATA_W'(key_shifts_ff);
         vle_pkg::REG_KEY_LENGTH:
            prdata = vle_pkg::DATA_W'(key_length_ff);
         default:
            prdata = '0;
      endcase
   end

   // Clamp the key length into 1..KEY_MAX
   always_comb begin
      eff_len = key_length_ff;
      if (eff_len == '0) begin
         eff_len = vle_pkg::LEN_W'(1);
      end
      if (eff_len > vle_pkg::LEN_W'(KEY_MAX)) begin
         eff_len = vle_pkg::LEN_W'(KEY_MAX);
      end
   end

   // Pick the key position for this byte: restart or an out-of-range
   // position falls back to entry zero
   always_comb begin
      cur_pos = key_pos_ff;
      if (s1_restart_ff || (cur_pos >= eff_len)) begin
         cur_pos = '0;
      end
   end

   // Select the key shift at the current position
   always_comb begin
      cur_shift = '0;
      for (int i = 0; i < KEY_MAX; i++) begin
         if (cur_pos == vle_pkg::POS_W'(i)) begin
            cur_shift = key_shifts_ff[i*vle_pkg::SHIFT_W +: vle_pkg::SHIFT_W];
         end
      end
   end

   // Classify the byte and encrypt letters
   assign is_upper = (s1_byte_ff >= vle_pkg::UPPER_A) && (s1_byte_ff <= vle_pkg::UPPER_Z);
   assign is_lower = (s1_byte_ff >= vle_pkg::LOWER_A) && (s1_byte_ff <= vle_pkg::LOWER_Z);
   assign letter_base = is_upper ? vle_pkg::UPPER_A : vle_pkg::LOWER_A;
   assign letter_ofs  = vle_pkg::SHIFT_W'(s1_byte_ff - letter_base);
   assign enc_ofs     = vle_pkg::add_mod26(letter_ofs, cur_shift);

   always_comb begin
      next_pos   = cur_pos;
      s2_byte_in = s2_byte_ff;
      if (is_upper || is_lower) begin
         next_pos = cur_pos + vle_pkg::POS_W'(1);
         if (next_pos >= eff_len) begin
            next_pos = '0;
         end
      end
      if (s1_advance) begin
         if (is_upper || is_lower) begin
            s2_byte_in = letter_base + vle_pkg::BYTE_W'(enc_ofs);
         end else begin
            s2_byte_in = s1_byte_ff;
         end
      end
   end

   // Update the key position with each transaction leaving stage 1; only letters step it forward
   assign key_pos_in = s1_advance ? next_pos : key_pos_ff;

   // Stage 1 capture
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_byte_in    = s1_byte_ff;
      s1_restart_in = s1_restart_ff;
      if (req_ready) begin
         s1_valid_in   = req_valid;
         s1_byte_in    = req_in_byte;
         s1_restart_in = req_restart;
      end
   end

   // Result slot: fill on advance, drop when taken
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_advance) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         key_pos_ff    <= '0;
         key_shifts_ff <= '0;
         key_length_ff <= vle_pkg::LEN_W'(1);
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         key_pos_ff    <= key_pos_in;
         key_shifts_ff <= key_shifts_in;
         key_length_ff <= key_length_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_restart_ff <= s1_restart_in;
      s2_byte_ff    <= s2_byte_in;
   end

`ifndef SYNTHESIS
   // Key position never leaves the key table
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      key_pos_ff < vle_pkg::POS_W'(KEY_MAX))
      else $error("key position out of range");

   // A non-letter leaving stage 1 comes out unchanged
   a_passthru: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !is_upper && !is_lower) |=> (s2_byte_ff == $past(s1_byte_ff)))
      else $error("non-letter byte modified");

   // An empty input register always takes a transaction
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input stalled while empty");

   // Key position holds unless a transaction advances
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(key_pos_ff))
      else $error("key position moved without a transaction");
`endif

endmodule
